// ----- rtl/cpk_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and command codes for the polynomial kernel block.
package cpk_pkg;

   localparam int MAX_LEN_DEF = 256;
   localparam int FRAC_BITS   = 30;
   localparam int SQRT_SHIFT  = 32;
   localparam int DEG_W       = 4;
   localparam int OP_W        = 4;

   localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
   localparam logic [OP_W-1:0] OP_ACC       = 4'd1;
   localparam logic [OP_W-1:0] OP_CAPTURE   = 4'd2;
   localparam logic [OP_W-1:0] OP_SQ_STEP   = 4'd3;
   localparam logic [OP_W-1:0] OP_SQ_NEXT   = 4'd4;
   localparam logic [OP_W-1:0] OP_SQ_END    = 4'd5;
   localparam logic [OP_W-1:0] OP_MUL_STEP  = 4'd6;
   localparam logic [OP_W-1:0] OP_DIV_LOAD  = 4'd7;
   localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd8;
   localparam logic [OP_W-1:0] OP_Q_SET     = 4'd9;
   localparam logic [OP_W-1:0] OP_NORM_NEXT = 4'd10;
   localparam logic [OP_W-1:0] OP_RAW_NEXT  = 4'd11;
   localparam logic [OP_W-1:0] OP_FIN       = 4'd12;

   localparam logic [1:0] REG_DEGREE    = 2'd0;
   localparam logic [1:0] REG_INHOMOG   = 2'd1;
   localparam logic [1:0] REG_NORMALIZE = 2'd2;

   typedef struct packed {
      logic signed [7:0] elem_a;
      logic signed [7:0] elem_b;
      logic              last;
   } req_type;

   typedef struct packed {
      logic signed [63:0] kernel_value;
      logic               saturated;
      logic               zero_norm;
   } rsp_type;

   typedef struct packed {
      logic [DEG_W-1:0] degree;
      logic             inhomogeneous;
      logic             normalize;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      k;
   } cmd_type;

   typedef struct packed {
      logic clip;
      logic zero;
   } status_type;

endpackage

// ----- rtl/cpk_dpath.sv -----
`timescale 1ns / 1ps
// Datapath: accumulators, square root, shared multiplier, divider and power steps.
module cpk_dpath #(
   parameter int MAX_LEN = cpk_pkg::MAX_LEN_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cpk_pkg::cmd_type     cmd,
   input  cpk_pkg::cfg_type     cfg,
   input  cpk_pkg::req_type     req_data,
   output cpk_pkg::status_type  status,
   output cpk_pkg::rsp_type     result
);

   localparam int L       = $clog2(MAX_LEN);
   localparam int CROSS_W = L + 16;
   localparam int SELF_W  = L + 15;
   localparam int MAG_W   = L + 15;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);
   localparam int F       = cpk_pkg::FRAC_BITS;
   localparam int DIV_W   = MAG_W + cpk_pkg::SQRT_SHIFT + F;
   localparam logic [63:0] ONE = 64'd1 << F;

   logic signed [CROSS_W-1:0] acc_cross_ff, acc_cross_in;
   logic [SELF_W-1:0]         acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      over_ff, over_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic                      neg_ff, neg_in, sat_ff, sat_in, zn_ff, zn_in;
   logic [63:0]               x_ff, x_in, y_ff, y_in;
   logic [127:0]              prod_ff, prod_in;
   logic [63:0]               sq_v_ff, sq_v_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;
   logic [63:0]               den_ff, den_in, rem_ff, rem_in;
   logic [DIV_W-1:0]          div_ff, div_in;

   logic signed [15:0] pab, paa, pbb;
   logic signed [CROSS_W:0] base;
   logic [CROSS_W:0]   mag_full;
   logic [SELF_W:0]    sum_a, sum_b;
   logic [63:0]        sq_t, lim, qclamp, xh, yh;
   logic [63:0]        pp;
   logic [64:0]        rem_sh;

   assign pab   = req_data.elem_a * req_data.elem_b;
   assign paa   = req_data.elem_a * req_data.elem_a;
   assign pbb   = req_data.elem_b * req_data.elem_b;
   assign base  = (CROSS_W+1)'(acc_cross_ff) + $signed({{CROSS_W{1'b0}}, cfg.inhomogeneous});
   assign mag_full = base[CROSS_W] ? (CROSS_W+1)'(-base) : (CROSS_W+1)'(base);
   assign sum_a = {1'b0, acc_a_ff} + (SELF_W+1)'(cfg.inhomogeneous);
   assign sum_b = {1'b0, acc_b_ff} + (SELF_W+1)'(cfg.inhomogeneous);
   assign sq_t  = sq_r_ff + sq_bit_ff;
   assign lim   = neg_ff ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
   assign qclamp = (div_ff > DIV_W'(ONE)) ? ONE : div_ff[63:0];
   assign xh    = cmd.k[1] ? {32'd0, x_ff[63:32]} : {32'd0, x_ff[31:0]};
   assign yh    = cmd.k[0] ? {32'd0, y_ff[63:32]} : {32'd0, y_ff[31:0]};
   assign pp    = xh[31:0] * yh[31:0];
   assign rem_sh = {rem_ff, div_ff[DIV_W-1]};

   assign status.clip = prod_ff > {64'd0, lim};
   assign status.zero = (x_ff == 64'd0) || (sq_r_ff == 64'd0);

   assign result.kernel_value = neg_ff ? -$signed(x_ff) : $signed(x_ff);
   assign result.saturated    = sat_ff;
   assign result.zero_norm    = zn_ff;

   always_comb begin
      acc_cross_in = acc_cross_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      cnt_in       = cnt_ff;
      over_in      = over_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sat_in       = sat_ff;
      zn_in        = zn_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      prod_in      = prod_ff;
      sq_v_in      = sq_v_ff;
      sq_r_in      = sq_r_ff;
      sq_bit_in    = sq_bit_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      unique case (cmd.op)
         cpk_pkg::OP_ACC: begin
            if (cnt_ff < CNT_W'(MAX_LEN)) begin
               acc_cross_in = acc_cross_ff + CROSS_W'(pab);
               acc_a_in     = acc_a_ff + SELF_W'(paa[14:0]);
               acc_b_in     = acc_b_ff + SELF_W'(pbb[14:0]);
               cnt_in       = cnt_ff + CNT_W'(1);
            end else begin
               over_in = 1'b1;
            end
         end
         cpk_pkg::OP_CAPTURE: begin
            mag_in    = mag_full[MAG_W-1:0];
            neg_in    = base[CROSS_W] & cfg.degree[0] | base[CROSS_W] & (cfg.degree == '0);
            sat_in    = over_ff;
            zn_in     = 1'b0;
            x_in      = 64'd1;
            y_in      = 64'(mag_full[MAG_W-1:0]);
            sq_v_in   = 64'(sum_a) << cpk_pkg::SQRT_SHIFT;
            sq_r_in   = 64'd0;
            sq_bit_in = 64'd1 << 62;
         end
         cpk_pkg::OP_SQ_STEP: begin
            if (sq_v_ff >= sq_t) begin
               sq_v_in = sq_v_ff - sq_t;
               sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
            end else begin
               sq_r_in = sq_r_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
         end
         cpk_pkg::OP_SQ_NEXT: begin
            x_in      = sq_r_ff;
            sq_v_in   = 64'(sum_b) << cpk_pkg::SQRT_SHIFT;
            sq_r_in   = 64'd0;
            sq_bit_in = 64'd1 << 62;
         end
         cpk_pkg::OP_SQ_END: begin
            y_in = sq_r_ff;
            if (status.zero) begin
               zn_in = 1'b1;
               x_in  = 64'd0;
            end
         end
         cpk_pkg::OP_MUL_STEP: begin
            unique case (cmd.k)
               2'd0:    prod_in = 128'(pp);
               2'd3:    prod_in = prod_ff + (128'(pp) << 64);
               default: prod_in = prod_ff + (128'(pp) << 32);
            endcase
         end
         cpk_pkg::OP_DIV_LOAD: begin
            den_in = prod_ff[63:0];
            rem_in = 64'd0;
            div_in = DIV_W'(mag_ff) << (cpk_pkg::SQRT_SHIFT + F);
         end
         cpk_pkg::OP_DIV_STEP: begin
            if (rem_sh >= {1'b0, den_ff}) begin
               rem_in = 64'(rem_sh - {1'b0, den_ff});
               div_in = {div_ff[DIV_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[63:0];
               div_in = {div_ff[DIV_W-2:0], 1'b0};
            end
         end
         cpk_pkg::OP_Q_SET: begin
            x_in = qclamp;
            y_in = qclamp;
         end
         cpk_pkg::OP_NORM_NEXT: begin
            x_in = prod_ff[F+63:F];
         end
         cpk_pkg::OP_RAW_NEXT: begin
            if (status.clip) begin
               x_in   = lim;
               sat_in = 1'b1;
            end else begin
               x_in = prod_ff[63:0];
            end
         end
         cpk_pkg::OP_FIN: begin
            acc_cross_in = '0;
            acc_a_in     = '0;
            acc_b_in     = '0;
            cnt_in       = '0;
            over_in      = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_cross_ff <= '0;
         acc_a_ff     <= '0;
         acc_b_ff     <= '0;
         cnt_ff       <= '0;
         over_ff      <= 1'b0;
      end else begin
         acc_cross_ff <= acc_cross_in;
         acc_a_ff     <= acc_a_in;
         acc_b_ff     <= acc_b_in;
         cnt_ff       <= cnt_in;
         over_ff      <= over_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      sat_ff    <= sat_in;
      zn_ff     <= zn_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      prod_ff   <= prod_in;
      sq_v_ff   <= sq_v_in;
      sq_r_ff   <= sq_r_in;
      sq_bit_ff <= sq_bit_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
   end

endmodule

// ----- rtl/cpk_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences accumulation, square roots, division and the power loop.
module cpk_ctrl #(
   parameter int MAX_LEN = cpk_pkg::MAX_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cpk_pkg::cfg_type    cfg,
   input  logic                req_valid,
   input  logic                req_last,
   input  logic                out_free,
   input  cpk_pkg::status_type status,
   output logic                req_ready,
   output cpk_pkg::cmd_type    cmd
);

   localparam int MAG_W  = $clog2(MAX_LEN) + 15;
   localparam int DIV_W  = MAG_W + cpk_pkg::SQRT_SHIFT + cpk_pkg::FRAC_BITS;
   localparam int STEP_W = $clog2(DIV_W);
   localparam int DW     = cpk_pkg::DEG_W;

   localparam logic [3:0] S_ACC   = 4'd0;
   localparam logic [3:0] S_CAP   = 4'd1;
   localparam logic [3:0] S_SQA   = 4'd2;
   localparam logic [3:0] S_SQB0  = 4'd3;
   localparam logic [3:0] S_SQB   = 4'd4;
   localparam logic [3:0] S_RB    = 4'd5;
   localparam logic [3:0] S_DMUL  = 4'd6;
   localparam logic [3:0] S_DLOAD = 4'd7;
   localparam logic [3:0] S_DIV   = 4'd8;
   localparam logic [3:0] S_QSET  = 4'd9;
   localparam logic [3:0] S_NMUL  = 4'd10;
   localparam logic [3:0] S_NNEXT = 4'd11;
   localparam logic [3:0] S_RMUL  = 4'd12;
   localparam logic [3:0] S_RCHK  = 4'd13;
   localparam logic [3:0] S_FIN   = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DW-1:0]     it_ff, it_in;
   logic [DW-1:0]     dlast;

   assign dlast     = (cfg.degree == '0) ? '0 : cfg.degree - DW'(1);
   assign req_ready = (state_ff == S_ACC);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      it_in    = it_ff;
      cmd.op   = cpk_pkg::OP_NONE;
      cmd.k    = step_ff[1:0];
      unique case (state_ff)
         S_ACC: begin
            if (req_valid) begin
               cmd.op = cpk_pkg::OP_ACC;
               if (req_last) state_in = S_CAP;
            end
         end
         S_CAP: begin
            cmd.op   = cpk_pkg::OP_CAPTURE;
            step_in  = '0;
            it_in    = '0;
            state_in = cfg.normalize ? S_SQA : S_RMUL;
         end
         S_SQA, S_SQB: begin
            cmd.op = cpk_pkg::OP_SQ_STEP;
            if (step_ff == STEP_W'(31)) begin
               step_in  = '0;
               state_in = (state_ff == S_SQA) ? S_SQB0 : S_RB;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_SQB0: begin
            cmd.op   = cpk_pkg::OP_SQ_NEXT;
            state_in = S_SQB;
         end
         S_RB: begin
            cmd.op   = cpk_pkg::OP_SQ_END;
            step_in  = '0;
            state_in = status.zero ? S_FIN : S_DMUL;
         end
         S_DMUL, S_NMUL, S_RMUL: begin
            cmd.op = cpk_pkg::OP_MUL_STEP;
            if (step_ff[1:0] == 2'd3) begin
               step_in = '0;
               unique case (state_ff)
                  S_DMUL:  state_in = S_DLOAD;
                  S_NMUL:  state_in = S_NNEXT;
                  default: state_in = S_RCHK;
               endcase
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_DLOAD: begin
            cmd.op   = cpk_pkg::OP_DIV_LOAD;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = cpk_pkg::OP_DIV_STEP;
            if (step_ff == STEP_W'(DIV_W - 1)) begin
               step_in  = '0;
               state_in = S_QSET;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_QSET: begin
            cmd.op   = cpk_pkg::OP_Q_SET;
            it_in    = DW'(1);
            state_in = (dlast == '0) ? S_FIN : S_NMUL;
         end
         S_NNEXT: begin
            cmd.op = cpk_pkg::OP_NORM_NEXT;
            if (it_ff == dlast) begin
               state_in = S_FIN;
            end else begin
               it_in    = it_ff + DW'(1);
               state_in = S_NMUL;
            end
         end
         S_RCHK: begin
            cmd.op = cpk_pkg::OP_RAW_NEXT;
            if (status.clip || it_ff == dlast) begin
               state_in = S_FIN;
            end else begin
               it_in    = it_ff + DW'(1);
               state_in = S_RMUL;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.op   = cpk_pkg::OP_FIN;
               state_in = S_ACC;
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACC;
         step_ff  <= '0;
         it_ff    <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         it_ff    <= it_in;
      end
   end

endmodule

// ----- rtl/char_polynomial_kernel.sv -----
`timescale 1ns / 1ps
// Top level: register port, controller, datapath and result register.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | req_data (elem_a, elem_b, last)
//  rsp     | out       | rsp_valid/ready    | rsp_data (kernel_value, saturated, zero_norm)
//  csr     | in/out    | psel/penable/pready| paddr, pwdata, prdata
//
// Element requests are taken one per cycle. After the last element the block stops
// taking requests while it closes the vectors (d = degree, zero taken as one):
// raw mode does d multiply steps, stopping early if the power clips; normalized mode
// runs two bit-serial square roots, then the divider (one quotient bit a cycle) and
// d-1 power steps, stopping after the roots on a zero denominator. The closing cycle
// waits while the result register is full. Reset is synchronous: degree 1, other fields 0.
module char_polynomial_kernel #(
   parameter int MAX_LEN = cpk_pkg::MAX_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cpk_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cpk_pkg::rsp_type  rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cpk_pkg::cfg_type    cfg_ff, cfg_in;
   cpk_pkg::cmd_type    cmd;
   cpk_pkg::status_type status;
   cpk_pkg::rsp_type    result;
   cpk_pkg::rsp_type    rsp_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                fin, out_free, wr;

   assign pready   = 1'b1;
   assign wr       = psel && penable && pwrite;
   assign fin      = (cmd.op == cpk_pkg::OP_FIN);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (paddr[3:2])
            cpk_pkg::REG_DEGREE:    cfg_in.degree        = pwdata[cpk_pkg::DEG_W-1:0];
            cpk_pkg::REG_INHOMOG:   cfg_in.inhomogeneous = pwdata[0];
            cpk_pkg::REG_NORMALIZE: cfg_in.normalize     = pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         cpk_pkg::REG_DEGREE:    prdata = 32'(cfg_ff.degree);
         cpk_pkg::REG_INHOMOG:   prdata = 32'(cfg_ff.inhomogeneous);
         cpk_pkg::REG_NORMALIZE: prdata = 32'(cfg_ff.normalize);
         default:                prdata = 32'd0;
      endcase
   end

   assign rsp_valid_in = fin || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{degree: cpk_pkg::DEG_W'(1), inhomogeneous: 1'b0, normalize: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin) rsp_data_ff <= result;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   cpk_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_last  (req_data.last),
      .out_free  (out_free),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   cpk_dpath #(.MAX_LEN(MAX_LEN)) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .status   (status),
      .result   (result)
   );

endmodule

// ----- rtl/cpk_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the polynomial kernel, bound to the top level.
module cpk_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input cpk_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cpk_pkg::rsp_type rsp_data,
   input logic             pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_close_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.last |=> !req_ready)
      else $error("request taken while closing vectors");

   a_zero_norm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_norm |-> rsp_data.kernel_value == 64'sd0)
      else $error("zero denominator with non-zero value");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind char_polynomial_kernel cpk_checker u_cpk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .pready    (pready)
);

// ----- tb/char_polynomial_kernel_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the polynomial kernel: streamed vectors, register phases.
module char_polynomial_kernel_test;
   import cpk_pkg::*;

   localparam int MAX_LEN     = 256;
   localparam int TARGET      = 1450;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 300;

   class kernel_scoreboard;
      rsp_type          pending[$];
      logic [DEG_W-1:0] degree = 1;
      logic             inhomog = 0;
      logic             norm_mode = 0;
      longint           dot_ab;
      longint unsigned  dot_aa, dot_bb;
      int               count;
      bit               dropped;

      function void clear();
         dot_ab = 0; dot_aa = 0; dot_bb = 0; count = 0; dropped = 0;
      endfunction

      function longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, bitv;
         r = 0;
         bitv = 64'h1 << 62;
         while (bitv > v) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (v >= r + bitv) begin
               v = v - (r + bitv);
               r = (r >> 1) + bitv;
            end else begin
               r = r >> 1;
            end
            bitv = bitv >> 2;
         end
         return r;
      endfunction

      function void note_request(req_type r);
         longint          a, b, base;
         longint unsigned mag, lim, acc, ra, rb, den, num, one, q, p;
         logic [127:0]    wide;
         int unsigned     d, c;
         bit              neg, sat, zn, clip;
         rsp_type         res;
         a = r.elem_a;
         b = r.elem_b;
         if (count < MAX_LEN) begin
            dot_ab += a * b;
            dot_aa += a * a;
            dot_bb += b * b;
            count++;
         end else begin
            dropped = 1;
         end
         if (!r.last) return;
         d = (degree == 0) ? 1 : degree;
         c = inhomog;
         base = dot_ab + c;
         mag = (base < 0) ? -base : base;
         neg = (base < 0) && d[0];
         sat = dropped;
         zn = 0;
         if (!norm_mode) begin
            lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
            acc = 1;
            clip = 0;
            for (int i = 0; i < d; i++) begin
               if (mag != 0 && acc > lim / mag) begin
                  clip = 1;
                  break;
               end
               acc = acc * mag;
            end
            if (clip) begin
               acc = lim;
               sat = 1;
            end
            res.kernel_value = neg ? -acc : acc;
         end else begin
            ra = int_sqrt((dot_aa + c) << SQRT_SHIFT);
            rb = int_sqrt((dot_bb + c) << SQRT_SHIFT);
            if (ra == 0 || rb == 0) begin
               zn = 1;
               res.kernel_value = 0;
            end else begin
               den = ra * rb;
               num = mag << SQRT_SHIFT;
               wide = {64'd0, num} << FRAC_BITS;
               wide = wide / den;
               q = wide[63:0];
               one = 64'h1 << FRAC_BITS;
               if (q > one) q = one;
               p = q;
               for (int i = 1; i < d; i++) begin
                  wide = {64'd0, p} * {64'd0, q};
                  wide = wide >> FRAC_BITS;
                  p = wide[63:0];
               end
               res.kernel_value = neg ? -p : p;
            end
         end
         res.saturated = sat;
         res.zero_norm = zn;
         pending.push_back(res);
         clear();
      endfunction

      function string check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) return "result with no request outstanding";
         want = pending.pop_front();
         if (got.kernel_value !== want.kernel_value)
            return $sformatf("kernel_value %0d, expected %0d", got.kernel_value,
                             want.kernel_value);
         if (got.saturated !== want.saturated)
            return $sformatf("saturated %0b, expected %0b", got.saturated, want.saturated);
         if (got.zero_norm !== want.zero_norm)
            return $sformatf("zero_norm %0b, expected %0b", got.zero_norm, want.zero_norm);
         return "";
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   rsp_type     rsp_data;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   kernel_scoreboard sb = new();
   int errors = 0;
   int sent = 0;
   int max_gap = 15;
   int max_stall = 15;
   int idle_cycles = 0;

   char_polynomial_kernel u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #4 clock = ~clock;

   task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      string msg;
      if (!reset && req_valid && req_ready) sb.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         msg = sb.check_result(rsp_data);
         if (msg != "") report(msg);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = $urandom_range(max_stall, 0);
         if (stall > 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      case (idx)
         REG_DEGREE:    sb.degree = val[DEG_W-1:0];
         REG_INHOMOG:   sb.inhomog = val[0];
         REG_NORMALIZE: sb.norm_mode = val[0];
         default: ;
      endcase
   endtask

   task send_pair(logic signed [7:0] a, logic signed [7:0] b, logic last);
      int gap;
      gap = $urandom_range(max_gap, 0);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{elem_a: a, elem_b: b, last: last};
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   function logic [7:0] rand_elem();
      case ($urandom_range(9, 0))
         0: return 8'h80;
         1: return 8'h7f;
         2: return 8'h00;
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   task send_vector(int len);
      for (int i = 0; i < len; i++) send_pair(rand_elem(), rand_elem(), i == len - 1);
   endtask

   task drain();
      @(posedge clock);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      int          cfg[12][3] = '{'{1,0,0}, '{0,0,0}, '{8,1,0}, '{15,0,0}, '{3,1,1},
                                  '{1,0,1}, '{8,0,1}, '{0,1,1}, '{15,1,1}, '{2,0,0},
                                  '{5,1,0}, '{7,0,1}};
      int          quota, len, sel;
      sb.clear();
      repeat (3) @(posedge clock);
      reset <= 0;
      for (int ph = 0; ph < 12; ph++) begin
         csr_write(REG_DEGREE, cfg[ph][0]);
         csr_write(REG_INHOMOG, cfg[ph][1]);
         csr_write(REG_NORMALIZE, cfg[ph][2]);
         max_gap = (ph % 3 == 1) ? 0 : 15;
         max_stall = (ph % 4 == 3) ? 0 : 15;
         if (ph == 0 || ph == 5) begin
            send_pair(8'sd127, 8'sd127, 1);
            send_pair(-8'sd128, -8'sd128, 1);
            send_pair(-8'sd128, 8'sd127, 1);
            send_pair(8'sd0, 8'sd0, 1);
            send_pair(8'sd0, 8'sd5, 1);
            send_pair(-8'sd128, 8'sd127, 0);
            send_pair(-8'sd1, 8'sd1, 1);
         end
         if (ph % 4 == 2) send_vector(258);
         quota = sent + (TARGET - sent) / (12 - ph);
         while (sent < quota) begin
            sel = $urandom_range(99, 0);
            if (sel < 80) len = $urandom_range(8, 1);
            else if (sel < 95) len = $urandom_range(64, 9);
            else if (sel < 99) len = $urandom_range(256, 65);
            else len = $urandom_range(300, 257);
            send_vector(len);
         end
         drain();
      end
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/cpk_pkg.sv
rtl/cpk_dpath.sv
rtl/cpk_ctrl.sv
rtl/char_polynomial_kernel.sv
rtl/cpk_checker.sv
tb/char_polynomial_kernel_test.sv
